>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check, disabled while rst is high.
`define WSDF_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check, disabled while rst is high.
`define WSDF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> rtl/wsdf_pkg.sv
package wsdf_pkg;

   typedef enum logic [1:0] {
      ST_PAYLOAD  = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_TRUNC    = 2'd2,
      ST_OVERFLOW = 2'd3
   } wsdf_status_type;

   // One classified result on its way from the parser to the output stage.
   typedef struct packed {
      wsdf_status_type status;
      logic            last;
      logic [7:0]      data;
      logic [7:0]      key;
   } wsdf_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wsdf_qstat_type;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = 2;
   localparam int QCNT_BITS = 3;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Extended length and masking key byte counts, minus one.
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

endpackage

>>> rtl/wsdf_if.sv
interface wsdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wsdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_last;
   logic [1:0] status;

   modport source (output valid, output payload_byte, output payload_last, output status,
                   input ready);
   modport sink   (input valid, input payload_byte, input payload_last, input status,
                   output ready);
endinterface

>>> rtl/wsdf_front.sv
module wsdf_front #(
   parameter int LEN_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   wsdf_req_if.sink                req_bus,
   input  wsdf_pkg::wsdf_qstat_type qstat,
   output logic                    push,
   output wsdf_pkg::wsdf_op_type   push_op
);
   import wsdf_pkg::*;

   typedef enum logic [5:0] {
      PH_FIRST = 6'b000001,
      PH_LEN   = 6'b000010,
      PH_EXT   = 6'b000100,
      PH_KEY   = 6'b001000,
      PH_PAY   = 6'b010000,
      PH_DONE  = 6'b100000
   } wsdf_phase_type;

   wsdf_phase_type      phase_ff, phase_in;
   logic [2:0]          count_ff, count_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [31:0]         key_ff, key_in;
   logic                mask_ff, mask_in;
   logic                long_ff, long_in;
   logic [1:0]          idx_ff, idx_in;

   logic        accept;
   logic        emit;
   logic        fin_len;
   logic        fin_hdr;
   logic [7:0]  b;
   logic [6:0]  l7;
   wsdf_op_type op;

   assign req_bus.ready = !qstat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign l7            = b[6:0];

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      mask_in  = mask_ff;
      long_in  = long_ff;
      idx_in   = idx_ff;
      emit     = 1'b0;
      fin_len  = 1'b0;
      fin_hdr  = 1'b0;
      op       = '0;

      case (phase_ff)
         PH_FIRST: begin
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            mask_in  = b[7];
            count_in = '0;
            len_in   = '0;
            if (l7 == LEN7_EXT16) begin
               long_in  = 1'b0;
               phase_in = PH_EXT;
            end else if (l7 == LEN7_EXT64) begin
               long_in  = 1'b1;
               phase_in = PH_EXT;
            end else begin
               len_in  = LEN_BITS'(l7);
               fin_len = 1'b1;
            end
         end
         PH_EXT: begin
            if (len_ff[LEN_BITS-1 -: 8] != 8'd0) begin
               phase_in  = PH_DONE;
               emit      = 1'b1;
               op.status = ST_OVERFLOW;
            end else begin
               len_in   = {len_ff[LEN_BITS-9:0], b};
               count_in = count_ff + 3'd1;
               if (count_ff == (long_ff ? EXT64_LAST : EXT16_LAST)) begin
                  fin_len = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in   = {key_ff[23:0], b};
            count_in = count_ff + 3'd1;
            if (count_ff == KEY_LAST) begin
               fin_hdr = 1'b1;
            end
         end
         PH_PAY: begin
            emit      = 1'b1;
            op.status = ST_PAYLOAD;
            op.data   = b;
            op.key    = key_ff[{~idx_ff, 3'b000} +: 8];
            op.last   = (len_ff == LEN_BITS'(1));
            if (op.last) begin
               phase_in = PH_DONE;
            end
            len_in = len_ff - LEN_BITS'(1);
            idx_in = idx_ff + 2'd1;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (fin_len) begin
         count_in = '0;
         if (mask_in) begin
            phase_in = PH_KEY;
         end else begin
            fin_hdr = 1'b1;
         end
      end

      if (fin_hdr) begin
         if (len_in == '0) begin
            phase_in  = PH_DONE;
            emit      = 1'b1;
            op.status = ST_EMPTY;
         end else begin
            phase_in = PH_PAY;
            idx_in   = '0;
         end
      end

      if (req_bus.end_of_buffer) begin
         if (phase_in != PH_DONE) begin
            emit      = 1'b1;
            op        = '0;
            op.status = ST_TRUNC;
         end
         phase_in = PH_FIRST;
         count_in = '0;
         len_in   = '0;
         key_in   = '0;
         mask_in  = 1'b0;
         long_in  = 1'b0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         count_ff <= '0;
         len_ff   <= '0;
         key_ff   <= '0;
         mask_ff  <= 1'b0;
         long_ff  <= 1'b0;
         idx_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         mask_ff  <= mask_in;
         long_ff  <= long_in;
         idx_ff   <= idx_in;
      end
   end

   assign push    = accept && emit;
   assign push_op = op;

endmodule

>>> rtl/wsdf_queue.sv
module wsdf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wsdf_pkg::wsdf_op_type    push_op,
   input  logic                     pop,
   output wsdf_pkg::wsdf_op_type    head_op,
   output wsdf_pkg::wsdf_qstat_type qstat
);
   import wsdf_pkg::*;

   wsdf_op_type          entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op     = entry_ff[rd_ptr_ff];
   assign qstat.full  = (cnt_ff == QCNT_BITS'(QDEPTH));
   assign qstat.empty = (cnt_ff == '0);

endmodule

>>> rtl/wsdf_back.sv
module wsdf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  wsdf_pkg::wsdf_op_type    head_op,
   input  wsdf_pkg::wsdf_qstat_type qstat,
   output logic                     pop,
   wsdf_rsp_if.source               rsp_bus
);
   import wsdf_pkg::*;

   logic            valid_ff, valid_in;
   logic [7:0]      byte_ff;
   logic            last_ff;
   wsdf_status_type status_ff;

   // Load the output register whenever it is empty or being drained.
   assign pop = !qstat.empty && (!valid_ff || rsp_bus.ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= head_op.data ^ head_op.key;
         last_ff   <= head_op.last;
         status_ff <= head_op.status;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.payload_byte = byte_ff;
   assign rsp_bus.payload_last = last_ff;
   assign rsp_bus.status       = status_ff;

endmodule

>>> rtl/websocket_frame_deframer.sv
// Channel   Direction  Transfer carries
// req_bus   in         data_byte, end_of_buffer (one received byte per transfer)
// rsp_bus   out        payload_byte, payload_last, status (zero or one per input)
//
// One input byte is accepted per cycle while the queue is not full; the header
// parser state machine decides its fate in that same cycle. A result passes
// through the four-entry queue and then the output register before it leaves.
// Reset is synchronous and active high; it returns the parser to the first
// header byte and empties the queue and output register.
// The input stalls only while the queue is full, which happens only after the
// result side has refused transfers.
`include "assert_macros.svh"

module websocket_frame_deframer #(
   parameter int LEN_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   wsdf_req_if.sink    req_bus,
   wsdf_rsp_if.source  rsp_bus
);
   import wsdf_pkg::*;

   logic           q_push;
   logic           q_pop;
   wsdf_op_type    q_push_op;
   wsdf_op_type    q_head_op;
   wsdf_qstat_type q_stat;

   // The front end parses the frame header and tags each byte that yields a
   // result: payload byte with its key byte, empty completion, truncation or
   // overflow. Bytes that yield nothing never enter the queue.
   wsdf_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .qstat   (q_stat),
      .push    (q_push),
      .push_op (q_push_op)
   );

   // The queue decouples parsing from the consumer so a stalled result side
   // does not stop the byte stream until the queue fills.
   wsdf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .head_op (q_head_op),
      .qstat   (q_stat)
   );

   // The back end applies the mask and holds the result in the output register.
   wsdf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_op (q_head_op),
      .qstat   (q_stat),
      .pop     (q_pop),
      .rsp_bus (rsp_bus)
   );

   // The parser must never push into a full queue.
   `WSDF_ASSERT_IMPL(a_no_overflow, clock, reset, q_push, !q_stat.full)
   // Popping needs something queued.
   `WSDF_ASSERT_IMPL(a_no_underflow, clock, reset, q_pop, !q_stat.empty)
   // Status results other than payload carry a zero byte and no last flag.
   `WSDF_ASSERT_IMPL(a_status_clean, clock, reset,
      rsp_bus.valid && (rsp_bus.status != ST_PAYLOAD),
      (rsp_bus.payload_byte == 8'd0) && !rsp_bus.payload_last)
   // Nothing is presented right after reset.
   `WSDF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_bus.valid)

endmodule

>>> dv/tb_websocket_frame_deframer.sv
package tb_wsdf_pkg;
   import wsdf_pkg::*;

   localparam int LEN_BITS = 32;

   typedef enum logic [5:0] {
      PH_HDR_FIRST = 6'b000001,
      PH_HDR_LEN   = 6'b000010,
      PH_HDR_EXT   = 6'b000100,
      PH_HDR_KEY   = 6'b001000,
      PH_PAYLOAD   = 6'b010000,
      PH_SKIP      = 6'b100000
   } parse_phase_type;

   typedef struct {
      logic [7:0]      payload;
      logic            last;
      wsdf_status_type status;
   } deframe_result_type;

   // Models the header parser and unmasker, and holds the results it predicts
   // until the block hands them out.
   class deframe_scoreboard;
      parse_phase_type       phase;
      logic [3:0]            field_cnt;
      logic [LEN_BITS-1:0]   frame_len;
      logic [LEN_BITS-1:0]   pay_pos;
      logic [31:0]           mask_key;
      bit                    masked;
      bit                    long_ext;
      deframe_result_type    pending_rsp_q[$];
      int                    mismatches;
      int                    parsed_bytes;
      int                    buffers_seen;
      int                    status_counts[4];

      function new();
         clear_frame();
      endfunction

      function void clear_frame();
         phase     = PH_HDR_FIRST;
         field_cnt = '0;
         frame_len = '0;
         pay_pos   = '0;
         mask_key  = '0;
         masked    = 1'b0;
         long_ext  = 1'b0;
      endfunction

      // Returns 1 when the frame turns out to be empty.
      function bit finish_header();
         if (frame_len == 0) begin
            phase = PH_SKIP;
            return 1'b1;
         end
         phase   = PH_PAYLOAD;
         pay_pos = '0;
         return 1'b0;
      endfunction

      function bit length_known();
         field_cnt = '0;
         if (masked) begin
            phase = PH_HDR_KEY;
            return 1'b0;
         end
         return finish_header();
      endfunction

      function void note_byte(logic [7:0] data, logic eob);
         deframe_result_type r;
         bit              emit;
         logic [6:0]      len7;
         int              key_idx;
         logic [LEN_BITS:0] next_pos;
         emit = 1'b0;
         r    = '{8'h00, 1'b0, ST_PAYLOAD};
         if (phase != PH_SKIP)
            parsed_bytes++;
         case (phase)
            PH_HDR_FIRST: phase = PH_HDR_LEN;
            PH_HDR_LEN: begin
               len7      = data[6:0];
               masked    = data[7];
               field_cnt = '0;
               frame_len = '0;
               if (len7 == LEN7_EXT16) begin
                  long_ext = 1'b0;
                  phase    = PH_HDR_EXT;
               end else if (len7 == LEN7_EXT64) begin
                  long_ext = 1'b1;
                  phase    = PH_HDR_EXT;
               end else begin
                  frame_len = LEN_BITS'(len7);
                  if (length_known()) begin
                     emit     = 1'b1;
                     r.status = ST_EMPTY;
                  end
               end
            end
            PH_HDR_EXT: begin
               if ((frame_len >> (LEN_BITS - 8)) != 0) begin
                  phase    = PH_SKIP;
                  emit     = 1'b1;
                  r.status = ST_OVERFLOW;
               end else begin
                  frame_len = {frame_len[LEN_BITS-9:0], data};
                  field_cnt = field_cnt + 4'd1;
                  if (field_cnt >= (long_ext ? 4'd8 : 4'd2)) begin
                     if (length_known()) begin
                        emit     = 1'b1;
                        r.status = ST_EMPTY;
                     end
                  end
               end
            end
            PH_HDR_KEY: begin
               mask_key  = {mask_key[23:0], data};
               field_cnt = field_cnt + 4'd1;
               if (field_cnt >= 4'd4) begin
                  if (finish_header()) begin
                     emit     = 1'b1;
                     r.status = ST_EMPTY;
                  end
               end
            end
            PH_PAYLOAD: begin
               key_idx   = int'(pay_pos[1:0]);
               r.payload = data ^ mask_key[31 - 8 * key_idx -: 8];
               r.status  = ST_PAYLOAD;
               emit      = 1'b1;
               next_pos  = {1'b0, pay_pos} + 1'b1;
               if (next_pos >= {1'b0, frame_len}) begin
                  r.last = 1'b1;
                  phase  = PH_SKIP;
               end
               pay_pos = next_pos[LEN_BITS-1:0];
            end
            default: phase = PH_SKIP;
         endcase
         if (eob) begin
            if (phase != PH_SKIP) begin
               emit = 1'b1;
               r    = '{8'h00, 1'b0, ST_TRUNC};
            end
            clear_frame();
            buffers_seen++;
         end
         if (emit)
            pending_rsp_q.push_back(r);
      endfunction

      function void check_result(logic [7:0] payload, logic last, logic [1:0] status);
         deframe_result_type exp;
         if (pending_rsp_q.size() == 0) begin
            $error("result with nothing pending: payload_byte=%0h payload_last=%0b status=%0d",
                   payload, last, status);
            mismatches++;
            return;
         end
         exp = pending_rsp_q.pop_front();
         status_counts[exp.status]++;
         if (status !== exp.status) begin
            $error("status: expected %0d (%s), actual %0d", exp.status, exp.status.name(),
                   status);
            mismatches++;
         end
         if (payload !== exp.payload) begin
            $error("payload_byte: expected %0h, actual %0h", exp.payload, payload);
            mismatches++;
         end
         if (last !== exp.last) begin
            $error("payload_last: expected %0b, actual %0b", exp.last, last);
            mismatches++;
         end
      endfunction
   endclass
endpackage

module tb_websocket_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import wsdf_pkg::*;
   import tb_wsdf_pkg::*;

   // Cycles without any transfer before the run is declared hung. The block
   // moves a byte per cycle unless the result queue is full, so only random
   // idling can hold things up, and never for anywhere near this long.
   localparam int WATCHDOG_LIMIT = 2000;
   // Spare cycles at the end catch anything the block might still emit after the
   // last expected one.
   localparam int DRAIN_CYCLES   = 12;
   localparam int BYTES_PER_PHASE = 225;

   typedef enum {FRAME_GOOD, FRAME_CUT, FRAME_OVERFLOW, FRAME_NOISE} frame_kind_type;

   logic clock;
   logic reset;

   wsdf_req_if req_bus ();
   wsdf_rsp_if rsp_bus ();

   deframe_scoreboard sb = new();

   // Percentages of cycles in which the sender holds back or the receiver
   // refuses a transfer; the main sequence changes them phase by phase.
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   // Bytes of the buffer being built, sent in order with the end flag on the
   // last one.
   logic [7:0] rx_buf[$];

   websocket_frame_deframer #(
      .LEN_BITS(LEN_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver decides anew at every edge whether it takes a result.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Transfers are sampled at the edge, before any of this edge's updates land,
   // so the values seen are the ones the block itself acted on.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            sb.note_byte(req_bus.data_byte, req_bus.end_of_buffer);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.payload_byte, rsp_bus.payload_last, rsp_bus.status);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $error("no transfer for %0d cycles, %0d results still pending", WATCHDOG_LIMIT,
             sb.pending_rsp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one byte, possibly after some idle cycles, and returns at the edge
   // where the transfer happens. Valid gets exactly one assignment per step, so
   // back-to-back bytes keep it high without a glitch.
   task automatic send_byte(logic [7:0] data, logic eob);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= data;
      req_bus.end_of_buffer <= eob;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic send_buffer();
      foreach (rx_buf[i])
         send_byte(rx_buf[i], i == rx_buf.size() - 1);
   endtask

   // Builds one buffer. Good frames carry a complete header and payload, cut
   // frames end somewhere short of that (sometimes with a huge announced
   // length), overflow frames announce a 64-bit length that does not fit, and
   // noise is a handful of arbitrary bytes.
   task automatic build_frame(frame_kind_type kind);
      int unsigned         pick;
      int unsigned         form;
      int unsigned         pay_cnt;
      int unsigned         keep;
      logic [LEN_BITS-1:0] frame_len;
      logic [63:0]         ext_len;
      bit                  mask_on;
      rx_buf.delete();
      rx_buf.push_back(8'($urandom));
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(0, 7))
            rx_buf.push_back(8'($urandom));
         return;
      end
      mask_on = $urandom_range(0, 1);
      if (kind == FRAME_OVERFLOW) begin
         rx_buf.push_back({mask_on, LEN7_EXT64});
         ext_len = {$urandom, $urandom};
         // A nonzero byte among the top four pushes the length past 32 bits.
         ext_len[63 - 8 * $urandom_range(0, 3) -: 8] = 8'($urandom_range(1, 255));
         for (int i = 7; i >= 0; i--)
            rx_buf.push_back(ext_len[8 * i +: 8]);
         repeat ($urandom_range(0, 3))
            rx_buf.push_back(8'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            keep = $urandom_range(3, rx_buf.size());
            while (rx_buf.size() > keep)
               void'(rx_buf.pop_back());
         end
         return;
      end

      // Length and its encoding: 7-bit, 16-bit extended or 64-bit extended.
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         form      = 0;
         frame_len = '0;
      end else if (pick < 60) begin
         form      = 0;
         frame_len = $urandom_range(1, 8);
      end else if (pick < 72) begin
         form      = 0;
         frame_len = $urandom_range(9, 125);
      end else if (pick < 86) begin
         form      = 1;
         frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 300)
                                                 : $urandom_range(0, 40);
      end else begin
         form      = 2;
         frame_len = $urandom_range(0, 40);
      end
      if (kind == FRAME_CUT && $urandom_range(0, 3) == 0) begin
         if (form == 2) begin
            frame_len = '1;
         end else begin
            form      = 1;
            frame_len = LEN_BITS'(16'hffff);
         end
      end

      case (form)
         0: rx_buf.push_back({mask_on, frame_len[6:0]});
         1: begin
            rx_buf.push_back({mask_on, LEN7_EXT16});
            rx_buf.push_back(frame_len[15:8]);
            rx_buf.push_back(frame_len[7:0]);
         end
         default: begin
            rx_buf.push_back({mask_on, LEN7_EXT64});
            ext_len = 64'(frame_len);
            for (int i = 7; i >= 0; i--)
               rx_buf.push_back(ext_len[8 * i +: 8]);
         end
      endcase
      if (mask_on) begin
         repeat (4)
            rx_buf.push_back(8'($urandom));
      end

      pay_cnt = frame_len;
      if (kind == FRAME_CUT && pay_cnt > 12)
         pay_cnt = $urandom_range(0, 12);
      repeat (pay_cnt)
         rx_buf.push_back(8'($urandom));

      if (kind == FRAME_CUT) begin
         keep = $urandom_range(1, rx_buf.size() - 1);
         while (rx_buf.size() > keep)
            void'(rx_buf.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
         // Bytes after the payload are dropped by the block.
         repeat ($urandom_range(1, 3))
            rx_buf.push_back(8'($urandom));
      end
   endtask

   function automatic frame_kind_type pick_kind();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return FRAME_GOOD;
      if (pick < 85)
         return FRAME_CUT;
      if (pick < 92)
         return FRAME_OVERFLOW;
      return FRAME_NOISE;
   endfunction

   initial begin
      int send_pct_by_phase[4];
      int recv_pct_by_phase[4];
      int target;
      send_pct_by_phase     = '{0, 56, 0, 37};
      recv_pct_by_phase     = '{0, 0, 56, 37};
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = 8'h00;
      req_bus.end_of_buffer = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed buffers, sent with no idling.
      // Unmasked frame with an empty payload: only the completion result.
      rx_buf = '{8'h81, 8'h00};
      send_buffer();
      // Masked one-byte payload; the key byte 0xff turns 0xff into 0x00.
      rx_buf = '{8'h82, 8'h81, 8'hff, 8'h00, 8'ha5, 8'h5a, 8'hff};
      send_buffer();
      // A buffer that ends on its very first byte is truncated.
      rx_buf = '{8'h00};
      send_buffer();
      // 64-bit length whose top byte is set: overflow reported on the byte
      // that also ends the buffer.
      rx_buf = '{8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
      send_buffer();
      // 16-bit extended length of one, followed by trailing bytes.
      rx_buf = '{8'h02, 8'h7e, 8'h00, 8'h01, 8'h00, 8'hff, 8'h00};
      send_buffer();

      // Random buffers in four phases: no idling, idle sender, stalling
      // receiver, and both at once.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct_by_phase[p];
         recv_stall_pct = recv_pct_by_phase[p];
         target         = sb.parsed_bytes + BYTES_PER_PHASE;
         while (sb.parsed_bytes < target) begin
            build_frame(pick_kind());
            send_buffer();
         end
      end
      req_bus.valid <= 1'b0;

      // Let the monitor take in the last transfer, wait for every expected
      // result, then watch a little longer for stray ones.
      @(posedge clock);
      while (sb.pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d buffers holding %0d header and payload bytes, in four idle phases.",
               sb.buffers_seen, sb.parsed_bytes);
      $display("Results checked: %0d payload, %0d empty, %0d truncated, %0d overflow.",
               sb.status_counts[ST_PAYLOAD], sb.status_counts[ST_EMPTY],
               sb.status_counts[ST_TRUNC], sb.status_counts[ST_OVERFLOW]);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/wsdf_pkg.sv
rtl/wsdf_if.sv
rtl/wsdf_front.sv
rtl/wsdf_queue.sv
rtl/wsdf_back.sv
rtl/websocket_frame_deframer.sv
dv/tb_websocket_frame_deframer.sv
